/* rtl/core/level_ancestor_jump_pointers_unit_defines.svh */
// Assertion macros used by the level-ancestor unit's controller.
`ifndef LEVEL_ANCESTOR_JUMP_POINTERS_UNIT_DEFINES_SVH
`define LEVEL_ANCESTOR_JUMP_POINTERS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAJP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("lajp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LAJP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("lajp assertion failed");

`endif

/* rtl/core/lajp_pkg.sv */
// Types, codes and helper functions of the level-ancestor unit.
package lajp_pkg;

	localparam int FIELD_W         = 10;
	localparam int FL_W            = $clog2(FIELD_W);
	localparam int IN_DATA_W       = 32;
	localparam int IN_USER_W       = 1;
	localparam int OUT_DATA_W      = 16;
	localparam int STATUS_W        = 2;
	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_JUMP_LEVELS = 10;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND  = 2'd0,
		ST_NO_ANC = 2'd1,
		ST_ADDED  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_DEP,
		S_ADD_ROW,
		S_Q_CHK,
		S_Q_ROW,
		S_RES
	} state_t;

	// source of the row memory read address
	typedef enum logic [1:0] {
		RS_PARENT,
		RS_CHAIN,
		RS_JUMP
	} row_src_t;

	typedef struct packed {
		logic     load_item;
		logic     dep_rd;
		logic     dep_from_jump;
		logic     add_init;
		logic     row_wr;
		logic     row_rd;
		row_src_t row_src;
		logic     k_inc;
		logic     q_advance;
		logic     res_load;
		status_t  res_code;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_is_query;
		logic in_add_ok;
		logic in_node_ok;
		logic top_zero;
		logic k_at_top;
		logic lvl_gt;
		logic lvl_eq;
		logic step_last;
		logic jump_ok;
		logic out_full;
	} dp_sts_t;

	// index of the highest set bit; zero for zero
	function automatic logic [FL_W-1:0] floor_log2(input logic [FIELD_W-1:0] v);
		logic [FL_W-1:0] r;
		r = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (v[i]) begin
				r = FL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/lajp_datapath.sv */
// Datapath of the level-ancestor unit: depth and jump memories, walk registers, result register.
module lajp_datapath #(
	parameter int MAX_NODES   = lajp_pkg::DEF_MAX_NODES,
	parameter int JUMP_LEVELS = lajp_pkg::DEF_JUMP_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lajp_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [lajp_pkg::IN_USER_W-1:0]      in_user,
	input  logic                                out_ready,
	input  lajp_pkg::ctl_cmd_t                  cmd,
	output lajp_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	output logic [lajp_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [lajp_pkg::STATUS_W-1:0]       out_user
);
	import lajp_pkg::*;

	localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LVL_W  = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
	localparam int STEP_W = $clog2(JUMP_LEVELS + 1);
	localparam logic [FIELD_W:0] DEPTH_MAX = (JUMP_LEVELS >= FIELD_W) ?
		(FIELD_W+1)'(2**FIELD_W - 1) : (FIELD_W+1)'(2**JUMP_LEVELS - 1);

	function automatic logic in_range(input logic [FIELD_W-1:0] v);
		return 32'(v) < 32'(MAX_NODES);
	endfunction

	logic [FIELD_W-1:0] dep_mem [MAX_NODES];
	logic [FIELD_W-1:0] row_mem [MAX_NODES][JUMP_LEVELS];

	logic [FIELD_W-1:0] in_node, in_parent, in_level;
	logic               in_query;
	logic [FIELD_W-1:0] node_q, parent_q, level_q, cur_q;
	logic [FIELD_W-1:0] dep_rd_q, row_rd_q;
	logic               dep_zero_q;
	logic [LVL_W-1:0]   k_q, top_q;
	logic [STEP_W-1:0]  step_q;
	logic [FIELD_W-1:0] anc_q;
	status_t            status_q;
	logic               out_valid_q;

	logic [FIELD_W-1:0] dep_addr, dep_val, diff, d_sat, wr_data, rr_node;
	logic [FIELD_W:0]   d_sum;
	logic [LVL_W-1:0]   wr_k, rr_k;
	logic [FL_W-1:0]    d_log;
	logic               row_fwd;

	assign in_node   = in_data[FIELD_W-1:0];
	assign in_parent = in_data[2*FIELD_W-1:FIELD_W];
	assign in_level  = in_data[3*FIELD_W-1:2*FIELD_W];
	assign in_query  = in_user[0] == CMD_QUERY;

	// root depth is fixed at zero and never stored
	assign dep_val = dep_zero_q ? '0 : dep_rd_q;
	assign diff    = dep_val - level_q;
	assign d_sum   = {1'b0, dep_val} + (FIELD_W+1)'(1);
	assign d_sat   = (d_sum > DEPTH_MAX) ? DEPTH_MAX[FIELD_W-1:0] : d_sum[FIELD_W-1:0];
	assign d_log   = floor_log2(d_sat);

	always_comb begin
		if (cmd.dep_from_jump) begin
			dep_addr = row_rd_q;
		end else if (in_query) begin
			dep_addr = in_node;
		end else begin
			dep_addr = in_parent;
		end
	end

	always_comb begin
		case (cmd.row_src)
			RS_PARENT: begin
				rr_node = parent_q;
				rr_k    = '0;
			end
			RS_CHAIN: begin
				rr_node = row_rd_q;
				rr_k    = k_q;
			end
			RS_JUMP: begin
				rr_node = cur_q;
				rr_k    = LVL_W'(floor_log2(diff));
			end
			default: begin
				rr_node = cur_q;
				rr_k    = '0;
			end
		endcase
	end

	// entry zero of a new row is the parent itself
	assign wr_k    = cmd.add_init ? '0 : k_q;
	assign wr_data = cmd.add_init ? parent_q : row_rd_q;

	// a row entry written in the same cycle reads back as the new value
	assign row_fwd = cmd.row_wr && (rr_node == node_q) && (rr_k == wr_k);

	always_ff @(posedge clk) begin
		if (cmd.dep_rd) begin
			dep_rd_q   <= dep_mem[NODE_W'(dep_addr)];
			dep_zero_q <= dep_addr == '0;
		end
		if (cmd.add_init) begin
			dep_mem[NODE_W'(node_q)] <= d_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_rd) begin
			row_rd_q <= row_fwd ? wr_data : row_mem[NODE_W'(rr_node)][rr_k];
		end
		if (cmd.row_wr) begin
			row_mem[NODE_W'(node_q)][wr_k] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			node_q   <= in_node;
			parent_q <= in_parent;
			level_q  <= in_level;
		end
		if (cmd.load_item) begin
			cur_q  <= in_node;
			step_q <= '0;
		end else if (cmd.q_advance) begin
			cur_q  <= row_rd_q;
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.add_init) begin
			top_q <= LVL_W'(d_log);
			k_q   <= LVL_W'(1);
		end else if (cmd.k_inc) begin
			k_q <= k_q + LVL_W'(1);
		end
		if (cmd.res_load) begin
			anc_q    <= (cmd.res_code == ST_FOUND) ? cur_q : '0;
			status_q <= cmd.res_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.in_is_query = in_query;
		sts.in_add_ok   = in_range(in_node) && in_range(in_parent) && (in_node != '0);
		sts.in_node_ok  = in_range(in_node);
		sts.top_zero    = d_log == '0;
		sts.k_at_top    = k_q == top_q;
		sts.lvl_gt      = level_q > dep_val;
		sts.lvl_eq      = level_q == dep_val;
		sts.step_last   = step_q == STEP_W'(JUMP_LEVELS);
		sts.jump_ok     = in_range(row_rd_q);
		sts.out_full    = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{(OUT_DATA_W-FIELD_W){1'b0}}, anc_q};
	assign out_user  = status_q;

endmodule

/* rtl/core/lajp_ctrl.sv */
// Controller state machine of the level-ancestor unit.
`include "level_ancestor_jump_pointers_unit_defines.svh"

module lajp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_ready,
	input  lajp_pkg::dp_sts_t  sts,
	output lajp_pkg::ctl_cmd_t cmd
);
	import lajp_pkg::*;

	state_t  state_q, state_d;
	status_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_ADDED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		code_d       = code_q;
		cmd          = '0;
		cmd.row_src  = RS_PARENT;
		cmd.res_code = code_q;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.dep_rd    = 1'b1;
					if (sts.in_is_query) begin
						if (sts.in_node_ok) begin
							state_d = S_Q_CHK;
						end else begin
							code_d  = ST_NO_ANC;
							state_d = S_RES;
						end
					end else if (sts.in_add_ok) begin
						state_d = S_ADD_DEP;
					end else begin
						code_d  = ST_ADDED;
						state_d = S_RES;
					end
				end
			end
			S_ADD_DEP: begin
				// store depth and row entry zero, then walk the parent's rows unless entry zero is the last
				cmd.add_init = 1'b1;
				cmd.row_wr   = 1'b1;
				if (sts.top_zero) begin
					code_d  = ST_ADDED;
					state_d = S_RES;
				end else begin
					cmd.row_rd  = 1'b1;
					cmd.row_src = RS_PARENT;
					state_d     = S_ADD_ROW;
				end
			end
			S_ADD_ROW: begin
				cmd.row_wr = 1'b1;
				if (sts.k_at_top) begin
					code_d  = ST_ADDED;
					state_d = S_RES;
				end else begin
					cmd.row_rd  = 1'b1;
					cmd.row_src = RS_CHAIN;
					cmd.k_inc   = 1'b1;
				end
			end
			S_Q_CHK: begin
				if (sts.lvl_gt) begin
					code_d  = ST_NO_ANC;
					state_d = S_RES;
				end else if (sts.lvl_eq) begin
					code_d  = ST_FOUND;
					state_d = S_RES;
				end else begin
					cmd.row_rd  = 1'b1;
					cmd.row_src = RS_JUMP;
					state_d     = S_Q_ROW;
				end
			end
			S_Q_ROW: begin
				// give up after the last allowed jump or on a bad node index
				if (sts.step_last || !sts.jump_ok) begin
					code_d  = ST_NO_ANC;
					state_d = S_RES;
				end else begin
					cmd.q_advance     = 1'b1;
					cmd.dep_rd        = 1'b1;
					cmd.dep_from_jump = 1'b1;
					state_d           = S_Q_CHK;
				end
			end
			S_RES: begin
				if (!sts.out_full || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`LAJP_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, state_q != S_IDLE)
	`LAJP_ASSERT_IMP(a_res_slot_free, clk, arst_n, cmd.res_load, !sts.out_full || out_ready)
	`LAJP_ASSERT_NXT(a_res_to_idle, clk, arst_n, cmd.res_load, state_q == S_IDLE)
	`LAJP_ASSERT_IMP(a_jump_bound, clk, arst_n, cmd.q_advance, !sts.step_last && sts.jump_ok)

endmodule

/* rtl/core/level_ancestor_jump_pointers_unit.sv */
// Top level of the level-ancestor unit: controller and datapath.
// Keeps a rooted tree (node 0 is the root at depth 0) in a depth memory and a jump-row memory
// and answers level-ancestor queries by binary lifting, one result word per input word.
// Items are taken one at a time; the next word is accepted once the result sits in the output
// register, even if that register has not been drained. An add builds the new row one entry
// per cycle through the single read port of the row memory; an add of the root or with an
// index out of range skips the row walk. A query makes at most JUMP_LEVELS jumps, each one row
// read followed by one depth read; a walk cut off after JUMP_LEVELS jumps or on a bad node index
// reports no ancestor, as does a query of an out-of-range node. A stalled output holds the
// result until the output register is free. No clearing pass follows reset: the root depth reads
// as zero without being stored.
module level_ancestor_jump_pointers_unit #(
	parameter int MAX_NODES   = lajp_pkg::DEF_MAX_NODES,
	parameter int JUMP_LEVELS = lajp_pkg::DEF_JUMP_LEVELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lajp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // node, parent, level, zero pad
	input  logic [lajp_pkg::IN_USER_W-1:0]  s_axis_tuser,  // command
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lajp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // ancestor, zero pad
	output logic [lajp_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
	import lajp_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	lajp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lajp_datapath #(
		.MAX_NODES   (MAX_NODES),
		.JUMP_LEVELS (JUMP_LEVELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

/* verif/level_ancestor_jump_pointers_unit_chk.sv */
// Checker of the level-ancestor unit: tracks the tree, predicts each answer, compares result words.
`timescale 1ns / 1ps
module level_ancestor_jump_pointers_unit_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [lajp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // node, parent, level, zero pad
	input  logic [lajp_pkg::IN_USER_W-1:0]  s_axis_tuser,  // command
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [lajp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // ancestor, zero pad
	input  logic [lajp_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
	output int unsigned                     pending,
	output int unsigned                     errors
);
	import lajp_pkg::*;

	localparam int NODES     = DEF_MAX_NODES;
	localparam int LEVELS    = DEF_JUMP_LEVELS;
	localparam int DEPTH_CAP = 1023;

	typedef struct packed {
		logic [FIELD_W-1:0] anc;
		status_t            code;
	} answer_t;

	answer_t            answer_q[$];
	logic [FIELD_W-1:0] depth_tab [NODES];
	logic [FIELD_W-1:0] jump_tab  [NODES][LEVELS];

	initial begin
		pending = 0;
		errors  = 0;
		for (int i = 0; i < NODES; i++) begin
			depth_tab[i] = '0;
			for (int k = 0; k < LEVELS; k++) begin
				jump_tab[i][k] = '0;
			end
		end
	end

	function automatic int msb_pos(input logic [FIELD_W-1:0] v);
		int pos;
		pos = 0;
		for (int i = 1; i < FIELD_W; i++) begin
			if (v[i]) begin
				pos = i;
			end
		end
		return pos;
	endfunction

	// hang node below parent and rebuild its jump row from the parent's rows
	function automatic void graft(input int node, input int parent);
		int d;
		int top;
		int hop;
		logic [FIELD_W-1:0] a;
		if (node == 0) begin
			return;
		end
		d = int'(depth_tab[parent]) + 1;
		if (d > DEPTH_CAP) begin
			d = DEPTH_CAP;
		end
		depth_tab[node] = FIELD_W'(d);
		top = msb_pos(FIELD_W'(d));
		jump_tab[node][0] = FIELD_W'(parent);
		hop = parent;
		for (int k = 1; k <= top && k < LEVELS; k++) begin
			a = jump_tab[hop][k-1];
			jump_tab[node][k] = a;
			hop = int'(a);
		end
	endfunction

	// take the largest power-of-two jump that does not climb past the target level
	function automatic answer_t climb(input int node, input int lvl);
		answer_t r;
		int cur;
		int d;
		r.anc  = '0;
		r.code = ST_NO_ANC;
		cur    = node;
		for (int hop_no = 0; hop_no <= LEVELS; hop_no++) begin
			d = int'(depth_tab[cur]);
			if (lvl > d) begin
				return r;
			end
			if (lvl == d) begin
				r.anc  = FIELD_W'(cur);
				r.code = ST_FOUND;
				return r;
			end
			cur = int'(jump_tab[cur][msb_pos(FIELD_W'(d - lvl))]);
		end
		return r;
	endfunction

	always @(posedge clk) begin : watch
		answer_t want;
		int node;
		int parent;
		int lvl;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				node   = int'(s_axis_tdata[FIELD_W-1:0]);
				parent = int'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
				lvl    = int'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
				if (s_axis_tuser[0] == CMD_ADD) begin
					graft(node, parent);
					want.anc  = '0;
					want.code = ST_ADDED;
				end else begin
					want = climb(node, lvl);
				end
				answer_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (answer_q.size() == 0) begin
					errors = errors + 1;
					$error("result word arrived with no answer pending");
				end else begin
					want = answer_q.pop_front();
					if (m_axis_tdata[FIELD_W-1:0] !== want.anc) begin
						errors = errors + 1;
						$error("ancestor: expected %0d, got %0d", want.anc,
							m_axis_tdata[FIELD_W-1:0]);
					end
					if (m_axis_tuser !== want.code) begin
						errors = errors + 1;
						$error("status: expected %0d, got %0d", want.code, m_axis_tuser);
					end
					if (m_axis_tdata[OUT_DATA_W-1:FIELD_W] !== '0) begin
						errors = errors + 1;
						$error("tdata pad: expected 0, got %0d",
							m_axis_tdata[OUT_DATA_W-1:FIELD_W]);
					end
				end
			end
		end
		pending <= answer_q.size();
	end

endmodule

/* verif/level_ancestor_jump_pointers_unit_tb.sv */
// Testbench top of the level-ancestor unit: drives tree adds and ancestor queries, gives the verdict.
`timescale 1ns / 1ps
module level_ancestor_jump_pointers_unit_tb;
	import lajp_pkg::*;

	localparam int NODES        = DEF_MAX_NODES;
	localparam int DEPTH_CAP    = 1023;
	localparam int RANDOM_WORDS = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	int unsigned           pending;
	int unsigned           errors;

	// stimulus-side view of the tree, used to choose legal words and to report the spine depth
	logic [FIELD_W-1:0] depth_of [NODES];
	bit                 present [NODES];
	bit                 in_spine [NODES];
	bit                 ever_parent [NODES];
	int                 spine[$];
	int                 parent_pool[$];
	int                 present_list[$];

	bit no_gaps;
	int rx_gap;
	int stall_left;
	int word_count;
	int adds_sent;
	int queries_sent;

	level_ancestor_jump_pointers_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	level_ancestor_jump_pointers_unit_chk u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.pending       (pending),
		.errors        (errors)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: drop ready for a drawn number of cycles after each word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if (m_axis_tvalid && m_axis_tready) begin
			rx_gap = no_gaps ? 0 : $urandom_range(0, 6);
			stall_left    <= rx_gap;
			m_axis_tready <= (rx_gap == 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic put_word(input logic cmd, input int node, input int parent, input int lvl);
		int gap;
		if (word_count % 100 == 0) begin
			no_gaps = ($urandom_range(0, 3) == 0);
		end
		word_count++;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= IN_DATA_W'({FIELD_W'(lvl), FIELD_W'(parent), FIELD_W'(node)});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_add(input int node, input int parent);
		int d;
		if (node != 0) begin
			d = int'(depth_of[parent]) + 1;
			depth_of[node] = FIELD_W'((d > DEPTH_CAP) ? DEPTH_CAP : d);
			if (!present[node]) begin
				present_list.push_back(node);
			end
			present[node]       = 1'b1;
			ever_parent[parent] = 1'b1;
		end
		adds_sent++;
		put_word(CMD_ADD, node, parent, $urandom_range(0, 1023));
	endtask

	task automatic send_query(input int node, input int lvl);
		queries_sent++;
		put_word(CMD_QUERY, node, $urandom_range(0, 1023), lvl);
	endtask

	task automatic random_query();
		int node;
		int d;
		int lvl;
		int pick;
		if ($urandom_range(0, 3) == 0) begin
			node = spine[$];
		end else begin
			node = present_list[$urandom_range(0, present_list.size() - 1)];
		end
		d    = int'(depth_of[node]);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			lvl = d;
		end else if (pick == 1 && d < DEPTH_CAP) begin
			lvl = $urandom_range(d + 1, DEPTH_CAP);
		end else if (pick == 2) begin
			lvl = 0;
		end else begin
			lvl = $urandom_range(0, d);
		end
		send_query(node, lvl);
	endtask

	// a node off the spine; unless any_outside, one that nobody hangs below
	function automatic int pick_leaf(input bit any_outside);
		int start;
		int id;
		start = $urandom_range(1, NODES - 1);
		for (int i = 0; i < NODES - 1; i++) begin
			id = 1 + (start - 1 + i) % (NODES - 1);
			if (!in_spine[id] && (any_outside || !ever_parent[id])) begin
				return id;
			end
		end
		return 0;
	endfunction

	task automatic grow_spine(input int node);
		send_add(node, spine[$]);
		in_spine[node] = 1'b1;
		spine.push_back(node);
		parent_pool.push_back(node);
	endtask

	initial begin
		#10_000_000;
		$display("** level_ancestor_jump_pointers_unit: FAILED **");
		$finish;
	end

	initial begin
		int node;
		int parent;
		int kind;
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		for (int i = 0; i < NODES; i++) begin
			depth_of[i] = '0;
		end
		present[0]  = 1'b1;
		in_spine[0] = 1'b1;
		present_list.push_back(0);
		spine.push_back(0);
		parent_pool.push_back(0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: root, small chain, overwrite, broken and looping trees
		send_query(0, 0);
		send_query(0, 1023);
		send_add(0, 1023);
		send_add(1, 0);
		send_add(2, 1);
		send_add(3, 2);
		send_add(1023, 3);
		send_query(1023, 0);
		send_query(1023, 4);
		send_query(1023, 1);
		send_query(1023, 5);
		send_query(1023, 1023);
		send_add(5, 1023);
		send_add(3, 0);
		send_query(5, 3);
		send_query(5, 0);
		send_add(7, 0);
		send_add(7, 7);
		send_query(7, 0);
		send_query(7, 1);

		// grow a consistent spine from the root, hang leaves off it, probe levels
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				node = pick_leaf(1'b0);
				if (node != 0) begin
					grow_spine(node);
				end else begin
					random_query();
				end
			end else if (kind < 72) begin
				node   = pick_leaf(1'b0);
				parent = parent_pool[$urandom_range(0, parent_pool.size() - 1)];
				if (node != 0 && node != parent) begin
					send_add(node, parent);
					parent_pool.push_back(node);
				end else begin
					random_query();
				end
			end else if (kind < 74) begin
				send_add(0, $urandom_range(0, NODES - 1));
			end else begin
				random_query();
			end
		end

		// push the spine to the depth cap, moving off-spine nodes as needed
		while (spine.size() <= DEPTH_CAP) begin
			node = pick_leaf(1'b0);
			if (node == 0) begin
				node = pick_leaf(1'b1);
			end
			grow_spine(node);
			if ($urandom_range(0, 15) == 0) begin
				random_query();
			end
		end

		// re-hang the shallowest spine nodes below the tip: depth saturates
		send_add(spine[1], spine[$]);
		send_add(spine[2], spine[1]);
		send_add(0, $urandom_range(0, NODES - 1));
		for (int i = 0; i < 40; i++) begin
			random_query();
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		$display("Ran %0d adds and %0d queries: directed corners, a spine up to depth %0d",
			adds_sent, queries_sent, int'(depth_of[spine[$]]));
		$display("with saturated re-hangs, overwritten nodes and broken-tree probes.");
		if (errors == 0 && pending == 0) begin
			$display("** level_ancestor_jump_pointers_unit: PASSED **");
		end else begin
			$display("** level_ancestor_jump_pointers_unit: FAILED **");
		end
		$finish;
	end

endmodule
